/* hdl/cle_pkg.sv */
// Shared types and constants for the console line editor.
// Holds the control/status structs between controller and datapath.
// No dependencies.
package cle_pkg;

    localparam logic [7:0] KEY_CR     = 8'h0d;
    localparam logic [7:0] KEY_LF     = 8'h0a;
    localparam logic [7:0] KEY_BELL   = 8'h07;
    localparam logic [7:0] KEY_BS     = 8'h08;
    localparam logic [7:0] KEY_SPACE  = 8'h20;
    localparam logic [7:0] KEY_PROMPT = 8'h3e;
    localparam logic [7:0] KEY_NUL    = 8'h00;

    localparam logic KIND_ECHO = 1'b0;
    localparam logic KIND_LINE = 1'b1;

    typedef enum logic [1:0] {
        OSEL_CONST,
        OSEL_CHAR,
        OSEL_MEM
    } out_sel_t;

    typedef struct packed {
        logic       latch_in;
        logic       store_wr;
        logic       fill_dec;
        logic       fill_clr;
        logic       rd_clr;
        logic       rd_inc;
        logic       out_load;
        out_sel_t   out_sel;
        logic [7:0] out_const;
        logic       out_kind;
        logic       out_last;
    } cle_cmd_t;

    typedef struct packed {
        logic is_cr;
        logic is_bs;
        logic full;
        logic empty;
        logic rd_last;
        logic out_free;
    } cle_status_t;

endpackage

/* hdl/cle_rx_if.sv */
// Request channel carrying one received console byte.
// No dependencies.
interface cle_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

/* hdl/cle_tx_if.sv */
// Result channel carrying one echo or command-line byte.
// No dependencies.
interface cle_tx_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       out_kind;
    logic       last;

    modport source (output valid, output out_byte, output out_kind, output last, input ready);
    modport sink (input valid, input out_byte, input out_kind, input last, output ready);
endinterface

/* hdl/cle_datapath.sv */
// Datapath of the console line editor: line memory, fill count, read index,
// latched input byte and the result register. Depends on cle_pkg.
module cle_datapath #(
    parameter int LINE_CAPACITY = 32
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  cle_pkg::cle_cmd_t    cmd,
    output cle_pkg::cle_status_t status,
    input  logic [7:0]           in_byte,
    input  logic                 tx_ready,
    output logic                 tx_valid,
    output logic [7:0]           tx_byte,
    output logic                 tx_kind,
    output logic                 tx_last
);

    localparam int FILL_W = $clog2(LINE_CAPACITY + 1);
    localparam int IDX_W  = $clog2(LINE_CAPACITY);

    logic [7:0]        line_mem [LINE_CAPACITY];
    logic [7:0]        rdata_reg;
    logic [7:0]        char_reg;
    logic [FILL_W-1:0] fill_reg;
    logic [FILL_W-1:0] fill_next;
    logic [IDX_W-1:0]  rd_idx_reg;
    logic [IDX_W-1:0]  rd_idx_next;
    logic              tx_valid_reg;
    logic              tx_valid_next;
    logic [7:0]        tx_byte_reg;
    logic              tx_kind_reg;
    logic              tx_last_reg;
    logic [7:0]        out_data;

    always_comb
    begin
        fill_next = fill_reg;
        if (cmd.fill_clr)
        begin
            fill_next = '0;
        end
        else if (cmd.store_wr)
        begin
            fill_next = fill_reg + FILL_W'(1);
        end
        else if (cmd.fill_dec)
        begin
            fill_next = fill_reg - FILL_W'(1);
        end
    end

    always_comb
    begin
        rd_idx_next = rd_idx_reg;
        if (cmd.rd_clr)
        begin
            rd_idx_next = '0;
        end
        else if (cmd.rd_inc)
        begin
            rd_idx_next = rd_idx_reg + IDX_W'(1);
        end
    end

    always_comb
    begin
        unique case (cmd.out_sel)
            cle_pkg::OSEL_CHAR: out_data = char_reg;
            cle_pkg::OSEL_MEM:  out_data = rdata_reg;
            default:            out_data = cmd.out_const;
        endcase
    end

    assign tx_valid_next = cmd.out_load ? 1'b1 : (tx_ready ? 1'b0 : tx_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg     <= '0;
            rd_idx_reg   <= '0;
            tx_valid_reg <= 1'b0;
        end
        else
        begin
            fill_reg     <= fill_next;
            rd_idx_reg   <= rd_idx_next;
            tx_valid_reg <= tx_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch_in)
        begin
            char_reg <= in_byte;
        end
        if (cmd.out_load)
        begin
            tx_byte_reg <= out_data;
            tx_kind_reg <= cmd.out_kind;
            tx_last_reg <= cmd.out_last;
        end
    end

    // The read port follows the next index, so rdata_reg always holds the
    // entry at the current index while the line is being dumped.
    always_ff @(posedge clk)
    begin
        if (cmd.store_wr)
        begin
            line_mem[fill_reg[IDX_W-1:0]] <= char_reg;
        end
        rdata_reg <= line_mem[rd_idx_next];
    end

    assign status.is_cr    = (char_reg == cle_pkg::KEY_CR);
    assign status.is_bs    = (char_reg == cle_pkg::KEY_BS);
    assign status.full     = (fill_reg == FILL_W'(LINE_CAPACITY));
    assign status.empty    = (fill_reg == '0);
    assign status.rd_last  = ((FILL_W'(rd_idx_reg) + FILL_W'(1)) == fill_reg);
    assign status.out_free = !tx_valid_reg || tx_ready;

    assign tx_valid = tx_valid_reg;
    assign tx_byte  = tx_byte_reg;
    assign tx_kind  = tx_kind_reg;
    assign tx_last  = tx_last_reg;

`ifndef ASSERT_OFF
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FILL_W'(LINE_CAPACITY))
        else $error("fill count beyond line capacity");

    a_store_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.store_wr |-> !status.full)
        else $error("store into a full line");

    a_dec_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.fill_dec |-> !status.empty)
        else $error("backspace on an empty line");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> status.out_free)
        else $error("pending result overwritten");
`endif

endmodule

/* hdl/cle_ctrl.sv */
// Controller of the console line editor: sequences the results of each
// received byte through the datapath. Depends on cle_pkg.
module cle_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  cle_pkg::cle_status_t status,
    output cle_pkg::cle_cmd_t    cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECIDE,
        S_ECHO_CR,
        S_ECHO_LF,
        S_DUMP,
        S_PROMPT,
        S_BELL,
        S_STORE,
        S_BS1,
        S_BS2,
        S_BS3,
        S_NUL
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next    = state_reg;
        cmd           = '0;
        cmd.out_sel   = cle_pkg::OSEL_CONST;
        cmd.out_const = cle_pkg::KEY_NUL;
        cmd.out_kind  = cle_pkg::KIND_ECHO;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.latch_in = 1'b1;
                    state_next   = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                priority if (status.is_cr)
                begin
                    state_next = S_ECHO_CR;
                end
                else if (status.full)
                begin
                    state_next = S_BELL;
                end
                else if (!status.is_bs)
                begin
                    state_next = S_STORE;
                end
                else if (!status.empty)
                begin
                    state_next = S_BS1;
                end
                else
                begin
                    state_next = S_NUL;
                end
            end
            S_ECHO_CR:
            begin
                cmd.out_const = cle_pkg::KEY_CR;
                cmd.rd_clr    = 1'b1;
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_ECHO_LF;
                end
            end
            S_ECHO_LF:
            begin
                cmd.out_const = cle_pkg::KEY_LF;
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = status.empty ? S_PROMPT : S_DUMP;
                end
            end
            S_DUMP:
            begin
                cmd.out_sel  = cle_pkg::OSEL_MEM;
                cmd.out_kind = cle_pkg::KIND_LINE;
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    if (status.rd_last)
                    begin
                        state_next = S_PROMPT;
                    end
                    else
                    begin
                        cmd.rd_inc = 1'b1;
                    end
                end
            end
            S_PROMPT:
            begin
                cmd.out_const = cle_pkg::KEY_PROMPT;
                cmd.out_last  = 1'b1;
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    cmd.fill_clr = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            S_BELL:
            begin
                cmd.out_const = cle_pkg::KEY_BELL;
                cmd.out_last  = 1'b1;
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            S_STORE:
            begin
                cmd.out_sel  = cle_pkg::OSEL_CHAR;
                cmd.out_last = 1'b1;
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    cmd.store_wr = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            S_BS1:
            begin
                cmd.out_const = cle_pkg::KEY_BS;
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    cmd.fill_dec = 1'b1;
                    state_next   = S_BS2;
                end
            end
            S_BS2:
            begin
                cmd.out_const = cle_pkg::KEY_SPACE;
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_BS3;
                end
            end
            S_BS3:
            begin
                cmd.out_const = cle_pkg::KEY_BS;
                cmd.out_last  = 1'b1;
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            S_NUL:
            begin
                cmd.out_const = cle_pkg::KEY_NUL;
                cmd.out_last  = 1'b1;
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

`ifndef ASSERT_OFF
    a_accept_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.latch_in |-> in_ready && in_valid)
        else $error("byte latched outside idle");

    a_decide_next: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.latch_in |=> (state_reg == S_DECIDE))
        else $error("accepted byte not decoded");

    a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.out_load && cmd.out_last) |=> (state_reg == S_IDLE))
        else $error("final result did not return to idle");
`endif

endmodule

/* hdl/console_line_editor_core.sv */
// Console line editor with echo: each received byte yields one or more echo
// or command-line results, the final one marked with last. An accepted byte
// is latched and decoded, then its results are loaded into the result
// register in turn: the byte itself for an ordinary byte, a bell for a full
// line, a NUL for an empty-line backspace, backspace, space and backspace
// for a backspace, and CR, LF, each stored byte and a prompt for a carriage
// return. The line memory delivers one stored byte per cycle while the sink
// does not stall, through its single registered read port. A sink that holds
// off a pending result delays the rest of the sequence. The next byte is
// taken once the last result of the previous one is loaded. Depends on
// cle_pkg, cle_rx_if, cle_tx_if, cle_ctrl and cle_datapath.
module console_line_editor_core #(
    parameter int LINE_CAPACITY = 32
) (
    input logic     clk,
    input logic     rst_n,
    cle_rx_if.sink  rx,
    cle_tx_if.source tx
);

    cle_pkg::cle_cmd_t    cmd;
    cle_pkg::cle_status_t status;

    cle_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (rx.valid),
        .in_ready (rx.ready),
        .status   (status),
        .cmd      (cmd)
    );

    cle_datapath #(
        .LINE_CAPACITY (LINE_CAPACITY)
    ) u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .status   (status),
        .in_byte  (rx.rx_byte),
        .tx_ready (tx.ready),
        .tx_valid (tx.valid),
        .tx_byte  (tx.out_byte),
        .tx_kind  (tx.out_kind),
        .tx_last  (tx.last)
    );

endmodule
